// ===== rtl/cpdf_pkg.sv =====
// Shared types and constants for the channel packet demultiplexer.
`timescale 1ns / 1ps

package cpdf_pkg;

    localparam logic [7:0] START_BYTE = 8'hF0;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_BADCH = 2'd2;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_CHAN   = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_LEN_HI = 5'b01000,
        PH_DATA   = 5'b10000
    } phase_t;

endpackage

// ===== rtl/cpdf_frame.sv =====
// Link frame decoder: start byte, channel, 16-bit length, payload.
`timescale 1ns / 1ps

module cpdf_frame #(
    parameter int CHANNELS = 2,
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_en,
    input  logic [7:0]      link_byte,
    output logic            push,
    output logic [CH_W-1:0] push_channel
);
    import cpdf_pkg::*;

    localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CH_W-1:0]   channel_reg;
    logic [CH_W-1:0]   channel_next;
    logic [15:0]       remain_reg;
    logic [15:0]       remain_next;
    logic              chan_ok;

    assign chan_ok = ({1'b0, link_byte} < CH_LIMIT);

    always_comb
    begin
        phase_next   = phase_reg;
        channel_next = channel_reg;
        remain_next  = remain_reg;
        push         = 1'b0;
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (link_byte == START_BYTE)
                    begin
                        phase_next = PH_CHAN;
                    end
                end
                PH_CHAN:
                begin
                    if (chan_ok)
                    begin
                        channel_next = link_byte[CH_W-1:0];
                        phase_next   = PH_LEN_LO;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_LEN_LO:
                begin
                    remain_next = {8'd0, link_byte};
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    remain_next = {link_byte, remain_reg[7:0]};
                    phase_next  = ({link_byte, remain_reg[7:0]} != 16'd0) ? PH_DATA : PH_START;
                end
                PH_DATA:
                begin
                    push        = 1'b1;
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1)
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    assign push_channel = channel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            channel_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            channel_reg <= channel_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ===== rtl/cpdf_ring_ptr.sv =====
// Read and write pointers of one channel's ring buffer.
`timescale 1ns / 1ps

module cpdf_ring_ptr #(
    parameter int DEPTH = 32,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             pop,
    output logic [IDX_W-1:0] rd_idx,
    output logic [IDX_W-1:0] wr_idx,
    output logic             empty
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] rd_reg;
    logic [IDX_W-1:0] rd_next;
    logic [IDX_W-1:0] wr_reg;
    logic [IDX_W-1:0] wr_next;
    logic [IDX_W-1:0] wr_inc;
    logic [IDX_W-1:0] rd_inc;

    assign wr_inc = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
    assign rd_inc = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;

    // full buffer: a push drops the oldest byte
    always_comb
    begin
        rd_next = rd_reg;
        wr_next = wr_reg;
        if (push)
        begin
            wr_next = wr_inc;
            if (wr_inc == rd_reg)
            begin
                rd_next = rd_inc;
            end
        end
        else if (pop)
        begin
            rd_next = rd_inc;
        end
    end

    assign rd_idx = rd_reg;
    assign wr_idx = wr_reg;
    assign empty  = (rd_reg == wr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

endmodule

// ===== rtl/channel_packet_demux_fifos.sv =====
// Top level: framed link demultiplexer with one ring buffer per channel.
//
//  Channel | Signals                                    | Direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, action, link_byte,     | into block
//          | read_channel                               |
//  out     | out_valid, out_stall, status, read_data    | out of block
//
// One item is accepted per cycle while in_stall is low; a read result appears
// in the cycle after its request, taken from the registered read port of the
// buffer memory. Link bytes produce no result. Reset clears the frame decoder
// and all ring pointers at once; buffer contents are not cleared.
// in_stall is high while a result is held under out_stall.
`timescale 1ns / 1ps

module channel_packet_demux_fifos #(
    parameter int CHANNELS = 2,
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [7:0]         link_byte,
    input  logic [3:0]         read_channel,
    output logic               out_valid,
    input  logic               out_stall,
    output cpdf_pkg::status_t  status,
    output logic [7:0]         read_data
);
    import cpdf_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WORDS  = CHANNELS * DEPTH;
    localparam int ADDR_W = $clog2(WORDS);
    localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);
    localparam logic [ADDR_W:0] DEPTH_A = (ADDR_W + 1)'(DEPTH);

    logic                  accept;
    logic                  byte_en;
    logic                  read_en;
    logic                  push;
    logic [CH_W-1:0]       push_channel;
    logic [CHANNELS-1:0]   push_vec;
    logic [CHANNELS-1:0]   pop_vec;
    logic [IDX_W-1:0]      rd_idx [CHANNELS];
    logic [IDX_W-1:0]      wr_idx [CHANNELS];
    logic [CHANNELS-1:0]   empty_vec;
    logic                  rd_ch_ok;
    logic [CH_W-1:0]       rd_sel;
    logic [ADDR_W:0]       wr_base;
    logic [ADDR_W:0]       rd_base;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  mem_re;
    status_t               status_next;

    logic [7:0]            mem [WORDS];
    logic [7:0]            rd_data_reg;
    logic                  out_valid_reg;
    status_t               status_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign byte_en  = accept & (action == ACT_BYTE);
    assign read_en  = accept & (action == ACT_READ);

    cpdf_frame #(
        .CHANNELS(CHANNELS)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_en      (byte_en),
        .link_byte    (link_byte),
        .push         (push),
        .push_channel (push_channel)
    );

    assign rd_ch_ok = ({5'd0, read_channel} < CH_LIMIT);
    assign rd_sel   = CH_W'(read_channel);

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        assign push_vec[i] = push & (push_channel == CH_W'(i));
        assign pop_vec[i]  = read_en & rd_ch_ok & (read_channel == 4'(i)) & ~empty_vec[i];

        cpdf_ring_ptr #(
            .DEPTH(DEPTH)
        ) u_ptr (
            .clk    (clk),
            .rst_n  (rst_n),
            .push   (push_vec[i]),
            .pop    (pop_vec[i]),
            .rd_idx (rd_idx[i]),
            .wr_idx (wr_idx[i]),
            .empty  (empty_vec[i])
        );
    end

    assign wr_base = (ADDR_W + 1)'(push_channel) * DEPTH_A;
    assign wr_addr = ADDR_W'(wr_base + (ADDR_W + 1)'(wr_idx[push_channel]));

    always_comb
    begin
        status_next = ST_BADCH;
        mem_re      = 1'b0;
        rd_base     = '0;
        rd_addr     = '0;
        if (rd_ch_ok)
        begin
            rd_base = (ADDR_W + 1)'(rd_sel) * DEPTH_A;
            rd_addr = ADDR_W'(rd_base + (ADDR_W + 1)'(rd_idx[rd_sel]));
            if (empty_vec[rd_sel])
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_OK;
                mem_re      = read_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= link_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_en)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= read_en;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_data = (status_reg == ST_OK) ? rd_data_reg : 8'd0;

    a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pop_vec))
        else $error("more than one ring popped in a cycle");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !((|push_vec) && (|pop_vec)))
        else $error("push and pop in the same cycle");

    a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_en |=> !out_valid)
        else $error("link byte produced a result");

    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (read_en && !rd_ch_ok) |=> (out_valid && status == ST_BADCH && read_data == 8'd0))
        else $error("out-of-range read not reported");

endmodule

// ===== verif/tb_channel_packet_demux_fifos.sv =====
// Testbench for channel_packet_demux_fifos: framed link traffic and reads checked by a predictor.
`timescale 1ns / 1ps

module tb_channel_packet_demux_fifos;
    import cpdf_pkg::*;

    localparam int CHANNELS = 2;
    localparam int DEPTH = 32;
    localparam int QUIET_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 630;

    typedef struct {
        logic       act;
        logic [7:0] lbyte;
        logic [3:0] rch;
    } link_item_t;

    typedef struct {
        status_t    st;
        logic [7:0] data;
    } read_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = ACT_BYTE;
    logic [7:0]  link_byte = 8'h00;
    logic [3:0]  read_channel = 4'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    status_t     status;
    logic [7:0]  read_data;

    link_item_t  link_items[$];
    read_reply_t pending_replies[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int          quiet_cycles = 0;
    int          queued_count = 0;
    int          accepted_count = 0;
    bit          in_taken = 1'b0;

    // predicted decoder and ring buffer state
    phase_t      fr_phase = PH_START;
    int          cur_chan = 0;
    logic [15:0] remaining = '0;
    logic [7:0]  byte_store[CHANNELS][DEPTH];
    int          rd_ptr[CHANNELS];
    int          wr_ptr[CHANNELS];

    channel_packet_demux_fifos #(
        .CHANNELS(CHANNELS),
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .link_byte(link_byte),
        .read_channel(read_channel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .read_data(read_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int next_slot(int i);
        return (i + 1) % DEPTH;
    endfunction

    function automatic void decode_link_byte(logic [7:0] b);
        case (fr_phase)
            PH_START:
                if (b == START_BYTE)
                    fr_phase = PH_CHAN;
            PH_CHAN:
                if (b < CHANNELS)
                begin
                    cur_chan = b;
                    fr_phase = PH_LEN_LO;
                end
                else
                    fr_phase = PH_START;
            PH_LEN_LO:
            begin
                remaining = {8'h00, b};
                fr_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                remaining[15:8] = b;
                fr_phase = (remaining != 0) ? PH_DATA : PH_START;
            end
            PH_DATA:
            begin
                byte_store[cur_chan][wr_ptr[cur_chan]] = b;
                wr_ptr[cur_chan] = next_slot(wr_ptr[cur_chan]);
                // full buffer: oldest byte is lost
                if (wr_ptr[cur_chan] == rd_ptr[cur_chan])
                    rd_ptr[cur_chan] = next_slot(rd_ptr[cur_chan]);
                remaining = remaining - 16'd1;
                if (remaining == 0)
                    fr_phase = PH_START;
            end
            default:
                fr_phase = PH_START;
        endcase
    endfunction

    function automatic read_reply_t serve_read(logic [3:0] ch);
        read_reply_t r;
        r.data = 8'h00;
        if (ch >= CHANNELS)
            r.st = ST_BADCH;
        else if (rd_ptr[ch] == wr_ptr[ch])
            r.st = ST_EMPTY;
        else
        begin
            r.st = ST_OK;
            r.data = byte_store[ch][rd_ptr[ch]];
            rd_ptr[ch] = next_slot(rd_ptr[ch]);
        end
        return r;
    endfunction

    // monitor: prediction on input accept, check on result accept, watchdog count
    always @(posedge clk)
    begin
        read_reply_t want;
        bit fired;
        fired = 1'b0;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                fired = 1'b1;
                in_taken = 1'b1;
                accepted_count++;
                if (action == ACT_READ)
                    pending_replies.push_back(serve_read(read_channel));
                else
                    decode_link_byte(link_byte);
            end
            if (out_valid && !out_stall)
            begin
                fired = 1'b1;
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    $error("read result with no request pending: status %0d read_data %0h",
                           status, read_data);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.st)
                    begin
                        errors++;
                        $error("status: expected %0d, got %0d", want.st, status);
                    end
                    if (read_data !== want.data)
                    begin
                        errors++;
                        $error("read_data: expected %0h, got %0h", want.data, read_data);
                    end
                end
            end
            quiet_cycles = fired ? 0 : quiet_cycles + 1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        link_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (in_taken || !in_valid)
            begin
                if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = link_items.pop_front();
                    in_valid <= 1'b1;
                    action <= it.act;
                    link_byte <= it.lbyte;
                    read_channel <= it.rch;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void queue_item(logic act, logic [7:0] lb, logic [3:0] rc);
        link_item_t it;
        it.act = act;
        it.lbyte = lb;
        it.rch = rc;
        link_items.push_back(it);
        queued_count++;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        queue_item(ACT_BYTE, b, 4'($urandom));
    endfunction

    function automatic void queue_read(logic [3:0] ch);
        queue_item(ACT_READ, 8'($urandom), ch);
    endfunction

    function automatic logic [3:0] pick_channel();
        if ($urandom_range(99) < 85)
            return 4'($urandom_range(CHANNELS - 1));
        return 4'($urandom_range(15));
    endfunction

    function automatic void queue_frame(logic [7:0] ch, logic [15:0] len);
        queue_byte(START_BYTE);
        queue_byte(ch);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 25)
                queue_read(pick_channel());
            queue_byte(($urandom_range(9) == 0) ? START_BYTE : 8'($urandom));
        end
    endfunction

    function automatic void queue_random_traffic(int count);
        int stop_at;
        int pick;
        logic [15:0] len;
        stop_at = queued_count + count;
        while (queued_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    len = 16'($urandom_range(12, 1));
                else if (pick < 98)
                    len = 16'($urandom_range(70, 13));
                else
                    len = 16'($urandom_range(300, 256));
                queue_frame(8'($urandom_range(CHANNELS - 1)), len);
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(6, 1)) queue_read(pick_channel());
            end
            else if (pick < 90)
            begin
                queue_byte(START_BYTE);
                if ($urandom_range(1) == 1)
                    queue_byte(8'($urandom_range(255, CHANNELS)));
                else
                begin
                    queue_byte(8'($urandom_range(CHANNELS - 1)));
                    queue_byte(8'h00);
                    queue_byte(8'h00);
                end
            end
            else
            begin
                repeat ($urandom_range(5, 1)) queue_byte(8'($urandom));
            end
        end
    endfunction

    task automatic wait_all_replies();
        while (accepted_count != queued_count || pending_replies.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_channel_packet_demux_fifos NOT OK");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 83;

        queue_read(4'd0);
        queue_read(4'd15);
        queue_item(ACT_READ, 8'hFF, 4'd2);
        queue_item(ACT_BYTE, 8'h00, 4'hF);
        queue_byte(8'hFF);
        // bad channel header, then a frame whose payload carries a start byte
        queue_byte(START_BYTE);
        queue_byte(8'h02);
        queue_byte(START_BYTE);
        queue_byte(8'h01);
        queue_byte(8'h02);
        queue_byte(8'h00);
        queue_byte(START_BYTE);
        queue_byte(8'hFF);
        // zero length header
        queue_byte(START_BYTE);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(START_BYTE);
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_read(4'd1);
        queue_read(4'd1);
        queue_read(4'd1);
        queue_read(4'd0);

        queue_random_traffic(ITEMS_PER_PHASE);
        wait_all_replies();

        send_idle_pct = 83;
        recv_idle_pct = 8;
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_all_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_all_replies();

        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("tb_channel_packet_demux_fifos OK");
        else
            $display("tb_channel_packet_demux_fifos NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cpdf_pkg.sv
rtl/cpdf_frame.sv
rtl/cpdf_ring_ptr.sv
rtl/channel_packet_demux_fifos.sv
verif/tb_channel_packet_demux_fifos.sv
